FILE: rtl/pose_plausibility_guard_defines.svh
// Assertion macros used by the checker file.
`ifndef POSE_PLAUSIBILITY_GUARD_DEFINES_SVH
`define POSE_PLAUSIBILITY_GUARD_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define PPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define PPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Fault codes, register indices, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam logic [2:0] FC_NONE    = 3'd0;
    localparam logic [2:0] FC_LATCHED = 3'd1;
    localparam logic [2:0] FC_NONFIN  = 3'd2;
    localparam logic [2:0] FC_QUAT    = 3'd3;
    localparam logic [2:0] FC_TRANS   = 3'd4;
    localparam logic [2:0] FC_YAW     = 3'd5;

    localparam int ATAN_LEN = 24;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;

    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_TRANS = 2'd1;
    localparam logic [1:0] REG_YAW   = 2'd2;

    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        case (i)
            5'd0:  atan_q24 = 24'd13176795;
            5'd1:  atan_q24 = 24'd7778716;
            5'd2:  atan_q24 = 24'd4110060;
            5'd3:  atan_q24 = 24'd2086331;
            5'd4:  atan_q24 = 24'd1047214;
            5'd5:  atan_q24 = 24'd524117;
            5'd6:  atan_q24 = 24'd262123;
            5'd7:  atan_q24 = 24'd131069;
            5'd8:  atan_q24 = 24'd65536;
            5'd9:  atan_q24 = 24'd32768;
            5'd10: atan_q24 = 24'd16384;
            5'd11: atan_q24 = 24'd8192;
            5'd12: atan_q24 = 24'd4096;
            5'd13: atan_q24 = 24'd2048;
            5'd14: atan_q24 = 24'd1024;
            5'd15: atan_q24 = 24'd512;
            5'd16: atan_q24 = 24'd256;
            5'd17: atan_q24 = 24'd128;
            5'd18: atan_q24 = 24'd64;
            5'd19: atan_q24 = 24'd32;
            5'd20: atan_q24 = 24'd16;
            5'd21: atan_q24 = 24'd8;
            5'd22: atan_q24 = 24'd4;
            5'd23: atan_q24 = 24'd2;
            default: atan_q24 = 24'd0;
        endcase
    endfunction

endpackage

FILE: rtl/ppg_cordic.sv
// ----------------------------------------------------------------------------
// ppg_cordic
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, atan2 in Q3.13.
// ----------------------------------------------------------------------------
module ppg_cordic #(
    parameter int STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [35:0] i_x,
    input  logic signed [35:0] i_y,
    output logic               o_done,
    output logic signed [15:0] o_yaw
);
    import ppg_pkg::*;

    localparam int NSTEP = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;

    // Vectors grow by about 1.65, so 38 bits hold them.
    logic signed [37:0] r_x, r_y;
    logic signed [27:0] r_z;
    logic [4:0]         r_i;
    logic               r_busy;
    logic               r_done;

    logic signed [37:0] xs, ys, x0, y0;
    logic signed [27:0] z0, at, zr;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = $signed({4'd0, atan_q24(r_i)});
        x0 = 38'(i_x);
        y0 = 38'(i_y);
        z0 = '0;
        // A left half plane vector is turned by a quarter turn first.
        if (i_x < 0) begin
            if (i_y >= 0) begin
                x0 = 38'(i_y);
                y0 = -38'(i_x);
                z0 = HALF_PI_Q24;
            end else begin
                x0 = -38'(i_y);
                y0 = 38'(i_x);
                z0 = -HALF_PI_Q24;
            end
        end
        zr = (r_z + 28'sd1024) >>> 11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= x0;
                r_y    <= y0;
                r_z    <= z0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end else if (r_y < 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end
                if (r_i == 5'(NSTEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_yaw  = zr[15:0];
endmodule

FILE: rtl/ppg_mac.sv
// ----------------------------------------------------------------------------
// ppg_mac
// Shared multiply-accumulate unit: one 34x34 signed product per cycle.
// ----------------------------------------------------------------------------
module ppg_mac (
    input  logic               i_clk,
    input  logic               i_clr,
    input  logic               i_en,
    input  logic               i_sub,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [69:0] o_acc
);
    logic signed [67:0] r_prod;
    logic               r_en, r_sub, r_clr;
    logic signed [69:0] r_acc;

    // Product is registered before it is accumulated.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_en   <= i_en;
        r_sub  <= i_sub;
        r_clr  <= i_clr;
        if (r_clr) begin
            r_acc <= '0;
        end else if (r_en) begin
            r_acc <= r_sub ? r_acc - 70'(r_prod) : r_acc + 70'(r_prod);
        end
    end

    assign o_acc = r_acc;
endmodule

FILE: rtl/pose_plausibility_guard.sv
// ----------------------------------------------------------------------------
// pose_plausibility_guard
// Odometry pose plausibility check with latched fault reporting.
// ----------------------------------------------------------------------------
// One item at a time. An evaluate item that runs every check passes the
// quaternion norm, the yaw vector, the CORDIC and the translation norm in turn
// before its result is offered; the next item can be taken once that result
// is offered and not stalled. The time is set by the one shared multiplier that
// forms these products and by the one-step-a-cycle CORDIC. A first sample or
// a per-axis translation fault skips the translation norm, a bad quaternion
// skips the yaw and translation checks, a non-finite sample skips every check,
// and reset items and items seen while latched go straight to the result. The
// result register holds a finished result while stalled.
module pose_plausibility_guard #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [15:0] i_quat_x,
    input  logic [15:0] i_quat_y,
    input  logic [15:0] i_quat_z,
    input  logic [15:0] i_quat_w,
    input  logic        i_any_non_finite,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_fault_code,
    output logic        o_is_latched,
    output logic [2:0]  o_held_fault
);
    import ppg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_NORM = 4'd1, S_NCHK = 4'd2,
                           S_YX = 4'd3, S_YY = 4'd4, S_CORD = 4'd5,
                           S_TRAN = 4'd6, S_TCHK = 4'd7, S_DONE = 4'd8,
                           S_OUT = 4'd9;

    logic [13:0] r_tol;
    logic [30:0] r_tjump;
    logic [14:0] r_yjump;

    logic signed [31:0] r_gx, r_gy, r_gz;
    logic signed [15:0] r_gyaw;
    logic               r_have, r_lat;
    logic [2:0]         r_lcode;

    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [35:0] r_xv;
    logic signed [15:0] r_yaw;
    logic [3:0]         r_st;
    logic [2:0]         r_cnt;
    logic [2:0]         n_cnt;
    logic               r_oval;
    logic [2:0]         r_code;

    logic               m_clr, m_en, m_sub;
    logic signed [33:0] m_a, m_b;
    logic signed [69:0] m_acc;
    logic               c_start, c_done;
    logic signed [15:0] c_yaw;

    ppg_mac u_mac (
        .i_clk(i_clk), .i_clr(m_clr), .i_en(m_en), .i_sub(m_sub),
        .i_a(m_a), .i_b(m_b), .o_acc(m_acc)
    );

    ppg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(c_start),
        .i_x(r_xv), .i_y(m_acc[35:0]), .o_done(c_done), .o_yaw(c_yaw)
    );

    logic        in_acc;
    logic [14:0] hi_b, lo_b;
    logic signed [32:0] dx, dy, dz, dsel;
    logic        any_big;
    logic signed [17:0] dyaw, wyaw;
    logic [17:0] ayaw;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE) || (r_oval && i_stall);

    always_comb begin
        hi_b = 15'd16384 + 15'(r_tol);
        lo_b = 15'd16384 - 15'(r_tol);
        dx = 33'(r_px) - 33'(r_gx);
        dy = 33'(r_py) - 33'(r_gy);
        dz = 33'(r_pz) - 33'(r_gz);
        any_big = ((dx < 0 ? -dx : dx) > $signed({2'b0, r_tjump})) ||
                  ((dy < 0 ? -dy : dy) > $signed({2'b0, r_tjump})) ||
                  ((dz < 0 ? -dz : dz) > $signed({2'b0, r_tjump}));
        dyaw = 18'(r_yaw) - 18'(r_gyaw);
        wyaw = dyaw;
        if (dyaw > PI_Q13) wyaw = dyaw - TWO_PI_Q13;
        else if (dyaw < -PI_Q13) wyaw = dyaw + TWO_PI_Q13;
        ayaw = wyaw < 0 ? 18'(-wyaw) : 18'(wyaw);
        case (r_cnt)
            3'd0: dsel = dx;
            3'd1: dsel = dy;
            default: dsel = dz;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt + 3'd1;
        case (r_st)
            S_IDLE, S_NCHK: n_cnt = '0;
            S_YX: if (r_cnt == 3'd6) n_cnt = '0;
            S_CORD: if (c_done) n_cnt = '0;
            default: ;
        endcase
    end

    // Operand selection for the shared multiplier, its clear and the CORDIC start.
    // Each phase issues a few products, then waits for the accumulator to settle.
    always_comb begin
        m_clr = 1'b0; m_en = 1'b0; m_sub = 1'b0;
        m_a = '0; m_b = '0;
        c_start = 1'b0;
        case (r_st)
            S_IDLE: m_clr = 1'b1;
            S_NORM: if (r_cnt < 3'd4) begin
                m_en = 1'b1;
                case (r_cnt)
                    3'd0: m_a = 34'(r_qx);
                    3'd1: m_a = 34'(r_qy);
                    3'd2: m_a = 34'(r_qz);
                    default: m_a = 34'(r_qw);
                endcase
                m_b = m_a;
            end
            S_NCHK, S_CORD, S_TCHK: m_clr = 1'b1;
            S_YX: if (r_cnt < 3'd4) begin
                m_en = 1'b1;
                m_sub = r_cnt[1];
                case (r_cnt)
                    3'd0: m_a = 34'(r_qw);
                    3'd1: m_a = 34'(r_qx);
                    3'd2: m_a = 34'(r_qy);
                    default: m_a = 34'(r_qz);
                endcase
                m_b = m_a;
            end else if (r_cnt == 3'd6) begin
                m_clr = 1'b1;
            end
            S_YY: if (r_cnt < 3'd2) begin
                m_en = 1'b1;
                m_a = r_cnt[0] ? 34'(r_qx) : 34'(r_qw);
                m_b = r_cnt[0] ? (34'(r_qy) <<< 1) : (34'(r_qz) <<< 1);
            end else if (r_cnt == 3'd4) begin
                c_start = 1'b1;
            end
            S_TRAN: if (r_cnt < 3'd3) begin
                m_en = 1'b1;
                m_a = 34'(dsel);
                m_b = 34'(dsel);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= 14'd164;
            r_tjump <= 31'd65536;
            r_yjump <= 15'd4096;
            r_gx <= '0; r_gy <= '0; r_gz <= '0; r_gyaw <= '0;
            r_have  <= 1'b0;
            r_lat   <= 1'b0;
            r_lcode <= FC_NONE;
            r_st    <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
            r_code  <= FC_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TOL:   r_tol   <= i_cfg_data[13:0];
                    REG_TRANS: r_tjump <= i_cfg_data;
                    REG_YAW:   r_yjump <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (r_oval && !i_stall) r_oval <= 1'b0;
            r_cnt <= n_cnt;
            case (r_st)
                S_IDLE: begin
                    if (in_acc) begin
                        r_px <= i_pos_x; r_py <= i_pos_y; r_pz <= i_pos_z;
                        r_qx <= i_quat_x; r_qy <= i_quat_y;
                        r_qz <= i_quat_z; r_qw <= i_quat_w;
                        if (i_operation) begin
                            r_gx <= '0; r_gy <= '0; r_gz <= '0; r_gyaw <= '0;
                            r_have <= 1'b0; r_lat <= 1'b0; r_lcode <= FC_NONE;
                            r_code <= FC_NONE;
                            r_st <= S_OUT;
                        end else if (r_lat) begin
                            r_code <= FC_LATCHED;
                            r_st <= S_OUT;
                        end else if (i_any_non_finite) begin
                            r_code <= FC_NONFIN;
                            r_st <= S_DONE;
                        end else begin
                            r_st <= S_NORM;
                        end
                    end
                end
                S_NORM: if (r_cnt == 3'd5) r_st <= S_NCHK;
                S_NCHK: begin
                    if (m_acc == 70'sd0 ||
                        m_acc > $signed(70'({15'd0, hi_b} * {15'd0, hi_b})) ||
                        m_acc < $signed(70'({15'd0, lo_b} * {15'd0, lo_b}))) begin
                        r_code <= FC_QUAT;
                        r_st <= S_DONE;
                    end else begin
                        r_st <= S_YX;
                    end
                end
                S_YX: if (r_cnt == 3'd6) begin
                    r_xv <= m_acc[35:0];
                    r_st <= S_YY;
                end
                S_YY: if (r_cnt == 3'd4) r_st <= S_CORD;
                S_CORD: if (c_done) begin
                    r_yaw <= c_yaw;
                    if (!r_have) begin
                        r_code <= FC_NONE;
                        r_st <= S_DONE;
                    end else if (any_big) begin
                        r_code <= FC_TRANS;
                        r_st <= S_DONE;
                    end else begin
                        r_st <= S_TRAN;
                    end
                end
                S_TRAN: if (r_cnt == 3'd4) r_st <= S_TCHK;
                S_TCHK: begin
                    if (m_acc > $signed(70'({31'd0, r_tjump} * {31'd0, r_tjump})))
                        r_code <= FC_TRANS;
                    else if (ayaw > 18'(r_yjump))
                        r_code <= FC_YAW;
                    else
                        r_code <= FC_NONE;
                    r_st <= S_DONE;
                end
                S_DONE: begin
                    if (r_code != FC_NONE) begin
                        r_lat <= 1'b1;
                        r_lcode <= r_code;
                    end else begin
                        r_gx <= r_px; r_gy <= r_py; r_gz <= r_pz;
                        r_gyaw <= r_yaw; r_have <= 1'b1;
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_oval <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_oval;
    assign o_fault_code = r_code;
    assign o_is_latched = r_lat;
    assign o_held_fault = r_lcode;
endmodule

FILE: rtl/ppg_checker.sv
// ----------------------------------------------------------------------------
// ppg_port_checks
// Port-level checks on the guard's handshake and latch reporting.
// ----------------------------------------------------------------------------
`include "pose_plausibility_guard_defines.svh"

module ppg_port_checks (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [2:0] o_fault_code,
    input logic       o_is_latched,
    input logic [2:0] o_held_fault
);
    import ppg_pkg::*;

    `PPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_fault_code))
    `PPG_ASSERT_IMPL(a_busy_while_out, i_clk, i_rst_n, o_valid && i_stall, o_stall)
    `PPG_ASSERT_IMPL(a_latch_code, i_clk, i_rst_n, o_valid, o_is_latched == (o_held_fault != FC_NONE))
    `PPG_ASSERT_IMPL(a_fault_latches, i_clk, i_rst_n, o_valid && o_fault_code != FC_NONE, o_is_latched)
endmodule

bind pose_plausibility_guard ppg_port_checks u_ppg_checker (.*);
